// File: hw/rtl/round_robin_sleep_scheduler_defines.svh
// Assertion macros for the round robin sleep scheduler.
// Used by the one RTL file with concurrent checks; no other dependencies.
`ifndef ROUND_ROBIN_SLEEP_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_SLEEP_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define RRSS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rrss assertion failed");
`define RRSS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrss assertion failed");
`else
`define RRSS_ASSERT(name, clk, rst, prop)
`define RRSS_ASSERT_IMP(name, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/rrss_pkg.sv
// Shared types and constants for the round robin sleep scheduler.
// No dependencies.
`timescale 1ns / 1ps
package rrss_pkg;
   localparam int MAX_THREADS = 16;
   localparam int SLOT_W      = $clog2(MAX_THREADS);

   localparam logic [2:0] OP_CREATE   = 3'd0;
   localparam logic [2:0] OP_SCHEDULE = 3'd1;
   localparam logic [2:0] OP_SLEEP    = 3'd2;
   localparam logic [2:0] OP_SET_ST   = 3'd3;

   localparam logic [1:0] ST_STOPPED = 2'd0;
   localparam logic [1:0] ST_RUNNING = 2'd1;
   localparam logic [1:0] ST_ENDED   = 2'd2;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_SLOT = 2'd1;
   localparam logic [1:0] KIND_IDLE = 2'd2;

   localparam logic CSR_MS_INTERVAL = 1'b0;
   localparam logic CSR_TIMER_COUNT = 1'b1;

   typedef struct packed {
      logic        valid;
      logic [1:0]  status;
      logic [31:0] wakeup;
   } slot_entry_type;
endpackage

// File: hw/rtl/rrss_cell.sv
// One slot cell of the scheduler ring: holds a slot entry, rotates to its neighbor.
// Depends on rrss_pkg.
`timescale 1ns / 1ps
module rrss_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift,
   input  logic                    wr,
   input  rrss_pkg::slot_entry_type wr_entry,
   input  rrss_pkg::slot_entry_type nbr_entry,
   output rrss_pkg::slot_entry_type entry
);
   rrss_pkg::slot_entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (shift) begin
         entry_ff <= nbr_entry;
      end else if (wr) begin
         entry_ff <= wr_entry;
      end
   end

   assign entry = entry_ff;
endmodule

// File: hw/rtl/rrss_conv.sv
// Sleep conversion: now + sleep_ms * ms_interval / timer_count, saturated; now if timer_count is 0.
// A multiply, then a restoring divider retiring one quotient bit a cycle.
`timescale 1ns / 1ps
module rrss_conv (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] now,
   input  logic [31:0] sleep_ms,
   input  logic [31:0] ms_interval,
   input  logic [31:0] timer_count,
   output logic        done,
   output logic [31:0] wakeup
);
   localparam logic [1:0] CV_IDLE = 2'd0;
   localparam logic [1:0] CV_MUL  = 2'd1;
   localparam logic [1:0] CV_DIV  = 2'd2;
   localparam logic [1:0] CV_FIN  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [31:0] a_ff, b_ff, div_ff, now_ff;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [31:0] wake_ff, wake_in;
   logic [32:0] sh, diff, sum;
   logic        ge;

   always_comb begin
      sh   = {rem_ff, quo_ff[63]};
      diff = sh - {1'b0, div_ff};
      ge   = sh >= {1'b0, div_ff};
      sum  = {1'b0, now_ff} + {1'b0, quo_ff[31:0]};
      state_in = state_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      wake_in  = wake_ff;
      unique case (state_ff)
         CV_IDLE: begin
            if (start) state_in = CV_MUL;
         end
         CV_MUL: begin
            rem_in = '0;
            cnt_in = '0;
            if (div_ff == '0) begin
               quo_in   = '0;
               state_in = CV_FIN;
            end else begin
               quo_in   = a_ff * b_ff;
               state_in = CV_DIV;
            end
         end
         CV_DIV: begin
            rem_in = ge ? diff[31:0] : sh[31:0];
            quo_in = {quo_ff[62:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd63) state_in = CV_FIN;
         end
         CV_FIN: begin
            done_in  = 1'b1;
            wake_in  = (quo_ff[63:32] != '0 || sum[32]) ? 32'hFFFF_FFFF : sum[31:0];
            state_in = CV_IDLE;
         end
         default: state_in = CV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      wake_ff <= wake_in;
      if (start && state_ff == CV_IDLE) begin
         a_ff   <= sleep_ms;
         b_ff   <= ms_interval;
         div_ff <= timer_count;
         now_ff <= now;
      end
   end

   assign done   = done_ff;
   assign wakeup = wake_ff;
endmodule

// File: hw/rtl/round_robin_sleep_scheduler.sv
// Round robin sleep scheduler. The slot table is a ring of cells that rotates one
// place a cycle while it shifts; every operation acts on the cell at the ring head.
// An item first rotates the ring to its slot, then create and schedule scan the ring
// one slot a cycle. Sleep adds the conversion unit: a multiply and a restoring divider.
// One item is in work at a time; a finished result waits in the output register.
`timescale 1ns / 1ps
`include "round_robin_sleep_scheduler_defines.svh"
module round_robin_sleep_scheduler (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_op,
   input  logic [31:0]                 req_now,
   input  logic [31:0]                 req_sleep_ms,
   input  logic [1:0]                  req_new_status,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rrss_pkg::SLOT_W-1:0] rsp_slot,
   output logic                        rsp_slot_ok,
   output logic                        rsp_idle,
   output logic                        rsp_full_res,
   output logic [1:0]                  rsp_active_status,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [31:0]                 csr_data
);
   localparam int N = rrss_pkg::MAX_THREADS;
   localparam int W = rrss_pkg::SLOT_W;
   localparam logic [W-1:0] LAST = W'(N - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ALIGN = 3'd1;
   localparam logic [2:0] S_OP    = 3'd2;
   localparam logic [2:0] S_CONV  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  op_ff;
   logic [31:0] now_ff, ms_ff;
   logic [1:0]  ns_ff;
   logic [W-1:0] target_ff, target_in, head_ff, head_in, cnt_ff, cnt_in;
   logic [W-1:0] act_ff, act_in;
   logic        pend_ff, pend_in;
   logic [1:0]  kind_ff, kind_in, shadow_ff, shadow_in;
   logic [W-1:0] res_slot_ff, res_slot_in;
   logic        res_ok_ff, res_ok_in, res_idle_ff, res_idle_in, res_full_ff, res_full_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_slot_ff;
   logic        rsp_ok_ff, rsp_idle_ff, rsp_full_ff;
   logic [1:0]  rsp_st_ff;
   logic [31:0] msi_ff, tic_ff;
   logic        accept, have_act, shift, cell0_wr, conv_start, conv_done;
   logic [31:0] conv_wake;
   logic [W-1:0] head_nx;
   rrss_pkg::slot_entry_type wr_entry, ring_tail, c0;
   rrss_pkg::slot_entry_type cell_q [N];

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         if (g == 0) begin : g_head
            rrss_cell u_cell (.clock(clock), .reset(reset), .shift(shift), .wr(cell0_wr),
                              .wr_entry(wr_entry), .nbr_entry(cell_q[1]), .entry(cell_q[0]));
         end else if (g == N - 1) begin : g_tail
            rrss_cell u_cell (.clock(clock), .reset(reset), .shift(shift), .wr(1'b0),
                              .wr_entry(wr_entry), .nbr_entry(ring_tail),
                              .entry(cell_q[g]));
         end else begin : g_mid
            rrss_cell u_cell (.clock(clock), .reset(reset), .shift(shift), .wr(1'b0),
                              .wr_entry(wr_entry), .nbr_entry(cell_q[g+1]),
                              .entry(cell_q[g]));
         end
      end
   endgenerate

   rrss_conv u_conv (
      .clock(clock), .reset(reset), .start(conv_start), .now(now_ff),
      .sleep_ms(ms_ff), .ms_interval(msi_ff), .timer_count(tic_ff),
      .done(conv_done), .wakeup(conv_wake)
   );

   assign c0        = cell_q[0];
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign have_act  = (kind_ff == rrss_pkg::KIND_SLOT);
   assign head_nx   = (head_ff == LAST) ? '0 : head_ff + 1'b1;
   // a retire write and a rotation can share a cycle: the tail takes the written entry
   assign ring_tail = cell0_wr ? wr_entry : c0;

   always_comb begin
      state_in    = state_ff;
      target_in   = target_ff;
      head_in     = head_ff;
      cnt_in      = cnt_ff;
      act_in      = act_ff;
      pend_in     = pend_ff;
      kind_in     = kind_ff;
      shadow_in   = shadow_ff;
      res_slot_in = res_slot_ff;
      res_ok_in   = res_ok_ff;
      res_idle_in = res_idle_ff;
      res_full_in = res_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      shift       = 1'b0;
      cell0_wr    = 1'b0;
      wr_entry    = c0;
      conv_start  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_slot_in = have_act ? act_ff : '0;
               res_ok_in   = have_act;
               res_idle_in = 1'b0;
               res_full_in = 1'b0;
               cnt_in      = '0;
               pend_in     = 1'b0;
               target_in   = act_ff;
               priority if (req_op == rrss_pkg::OP_CREATE) begin
                  target_in = '0;
                  state_in  = S_ALIGN;
               end else if (req_op == rrss_pkg::OP_SCHEDULE) begin
                  target_in = have_act ? act_ff : '0;
                  pend_in   = have_act;
                  state_in  = S_ALIGN;
               end else if (req_op == rrss_pkg::OP_SLEEP && have_act) begin
                  state_in = S_ALIGN;
               end else if (req_op == rrss_pkg::OP_SET_ST && have_act &&
                            req_new_status != 2'd3) begin
                  state_in = S_ALIGN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_ALIGN: begin
            if (head_ff == target_ff) begin
               state_in = S_OP;
            end else begin
               shift   = 1'b1;
               head_in = head_nx;
            end
         end
         S_OP: begin
            priority if (op_ff == rrss_pkg::OP_CREATE) begin
               if (!c0.valid) begin
                  cell0_wr    = 1'b1;
                  wr_entry    = '{valid: 1'b1, status: rrss_pkg::ST_STOPPED, wakeup: '0};
                  res_slot_in = head_ff;
                  res_ok_in   = 1'b1;
                  state_in    = S_DONE;
               end else if (cnt_ff == LAST) begin
                  res_slot_in = '0;
                  res_ok_in   = 1'b0;
                  res_full_in = 1'b1;
                  state_in    = S_DONE;
               end else begin
                  shift   = 1'b1;
                  head_in = head_nx;
                  cnt_in  = cnt_ff + 1'b1;
               end
            end else if (op_ff == rrss_pkg::OP_SCHEDULE) begin
               if (pend_ff) begin
                  // retire the outgoing thread, then the scan starts at the next slot
                  cell0_wr = 1'b1;
                  if (c0.status == rrss_pkg::ST_ENDED) begin
                     wr_entry = '{valid: 1'b0, status: rrss_pkg::ST_STOPPED, wakeup: '0};
                  end else if (c0.status == rrss_pkg::ST_RUNNING) begin
                     wr_entry.status = rrss_pkg::ST_STOPPED;
                  end
                  shift   = 1'b1;
                  head_in = head_nx;
                  pend_in = 1'b0;
               end else if (c0.valid && c0.wakeup <= now_ff) begin
                  cell0_wr        = 1'b1;
                  wr_entry.status = rrss_pkg::ST_RUNNING;
                  act_in          = head_ff;
                  kind_in         = rrss_pkg::KIND_SLOT;
                  shadow_in       = rrss_pkg::ST_RUNNING;
                  res_slot_in     = head_ff;
                  res_ok_in       = 1'b1;
                  state_in        = S_DONE;
               end else if (cnt_ff == LAST) begin
                  kind_in     = rrss_pkg::KIND_IDLE;
                  res_slot_in = '0;
                  res_ok_in   = 1'b0;
                  res_idle_in = 1'b1;
                  state_in    = S_DONE;
               end else begin
                  shift   = 1'b1;
                  head_in = head_nx;
                  cnt_in  = cnt_ff + 1'b1;
               end
            end else if (op_ff == rrss_pkg::OP_SLEEP) begin
               conv_start = 1'b1;
               state_in   = S_CONV;
            end else begin
               cell0_wr        = 1'b1;
               wr_entry.status = ns_ff;
               shadow_in       = ns_ff;
               state_in        = S_DONE;
            end
         end
         S_CONV: begin
            if (conv_done) begin
               cell0_wr        = 1'b1;
               wr_entry.wakeup = conv_wake;
               state_in        = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         act_ff       <= '0;
         kind_ff      <= rrss_pkg::KIND_NONE;
         shadow_ff    <= rrss_pkg::ST_STOPPED;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         msi_ff       <= 32'd1;
         tic_ff       <= 32'd1;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         act_ff       <= act_in;
         kind_ff      <= kind_in;
         shadow_ff    <= shadow_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == rrss_pkg::CSR_MS_INTERVAL) msi_ff <= csr_data;
            if (csr_index == rrss_pkg::CSR_TIMER_COUNT) tic_ff <= csr_data;
         end
      end
      target_ff   <= target_in;
      res_slot_ff <= res_slot_in;
      res_ok_ff   <= res_ok_in;
      res_idle_ff <= res_idle_in;
      res_full_ff <= res_full_in;
      if (accept) begin
         op_ff  <= req_op;
         now_ff <= req_now;
         ms_ff  <= req_sleep_ms;
         ns_ff  <= req_new_status;
      end
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_slot_ff <= res_slot_ff;
         rsp_ok_ff   <= res_ok_ff;
         rsp_idle_ff <= res_idle_ff;
         rsp_full_ff <= res_full_ff;
         rsp_st_ff   <= have_act ? shadow_ff : rrss_pkg::ST_STOPPED;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_slot_ok       = rsp_ok_ff;
   assign rsp_idle          = rsp_idle_ff;
   assign rsp_full_res      = rsp_full_ff;
   assign rsp_active_status = rsp_st_ff;

   `RRSS_ASSERT_IMP(a_accept_leaves_idle, clock, reset, accept, ##1 state_ff != S_IDLE)
   `RRSS_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_DONE))
   `RRSS_ASSERT_IMP(a_conv_in_wait, clock, reset, conv_done, state_ff == S_CONV)
   `RRSS_ASSERT_IMP(a_ok_idle_excl, clock, reset, rsp_valid_ff, !(rsp_ok_ff && rsp_idle_ff))
endmodule
